>>> hw/rtl/hbt_pkg.sv
package hbt_pkg;

  // field widths of one request and one result
  localparam int unsigned TILE_ID_W   = 64;
  localparam int unsigned ZOOM_W      = 5;
  localparam int unsigned POS_W       = 31;
  localparam int unsigned OUT_TDATA_W = 72;

  // number of zoom levels (0 to 31) the numbering can describe in a 64-bit id
  localparam int unsigned ZOOM_LEVELS_DEF = 32;

  // column / row pair carried through the hilbert walk
  typedef struct packed {
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] x;
  } coord_t;

endpackage

>>> hw/rtl/hilbert_tile_id_to_zxy_unit.sv
// hilbert tile id to zoom / column / row decoder. each request on the slave stream carries one
// 64-bit tile id (numbered along a hilbert curve, level after level, level z starting at
// (4^z-1)/3) and yields exactly one result on the master stream: zoom level, column and row,
// plus an out-of-range flag in tuser for ids past the last level (then zoom, x and y are zero).
// the unit works on one id at a time: a level search runs through the levels in turn on a single
// 64-bit compare/subtract, then a single d2xy step unit walks the levels of the found zoom, then
// the finish state loads the output register and the idle state takes the next request; a result
// still held in the output register delays the load.
// a finished result waits in the output register while the next request is taken.
module hilbert_tile_id_to_zxy_unit #(
  parameter int unsigned ZOOM_LEVELS = hbt_pkg::ZOOM_LEVELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [hbt_pkg::TILE_ID_W-1:0]    s_axis_tdata,   // [63:0] tile_id
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [hbt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // [4:0] zoom_level, [35:5] x_position,
                                                           // [66:36] y_position, [71:67] zero
  output logic                             m_axis_tuser    // [0] out_of_range
);

  localparam int unsigned IdW   = hbt_pkg::TILE_ID_W;
  localparam int unsigned ZoomW = hbt_pkg::ZOOM_W;
  localparam int unsigned PosW  = hbt_pkg::POS_W;
  localparam int unsigned OutW  = hbt_pkg::OUT_TDATA_W;
  localparam int unsigned PadW  = OutW - ZoomW - 2 * PosW;
  // level counter must reach ZOOM_LEVELS itself to flag an id past the last level
  localparam int unsigned ZcW   = $clog2(ZOOM_LEVELS + 1);

  // sequencer states
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSearch = 2'd1;
  localparam logic [1:0] StWalk   = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IdW-1:0]   rem_q, rem_d;       // id minus first id of the level, then the walk digits
  logic [IdW-1:0]   count_q, count_d;   // ids in the level under test, 4^z
  logic [ZcW-1:0]   zcnt_q, zcnt_d;     // level under test
  logic [ZoomW-1:0] zoom_q, zoom_d;
  logic [ZoomW-1:0] kcnt_q, kcnt_d;     // walk step
  logic [PosW-1:0]  span_q, span_d;     // walk span s = 2^k
  logic             oor_q, oor_d;
  hbt_pkg::coord_t  coord_q, coord_d;
  hbt_pkg::coord_t  coord_step;

  logic             m_valid_q, m_valid_d;
  logic [OutW-1:0]  m_data_q, m_data_d;
  logic             m_user_q, m_user_d;

  logic             in_take;
  logic             out_load;
  logic             rem_fits;

  assign s_axis_tready = (state_q == StIdle);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == StFinish) && (!m_valid_q || m_axis_tready);
  // shared wide compare: the remaining id falls inside the level under test
  assign rem_fits      = rem_q < count_q;

  // one shared d2xy step, fed the two lowest remaining bits
  hbt_d2xy_step u_step (
    .coord_i (coord_q),
    .span_i  (span_q),
    .digit_i (rem_q[1:0]),
    .coord_o (coord_step)
  );

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    count_d = count_q;
    zcnt_d  = zcnt_q;
    zoom_d  = zoom_q;
    kcnt_d  = kcnt_q;
    span_d  = span_q;
    oor_d   = oor_q;
    coord_d = coord_q;
    case (state_q)
      StIdle: begin
        if (in_take) begin
          rem_d   = s_axis_tdata;
          count_d = IdW'(1);
          zcnt_d  = '0;
          state_d = StSearch;
        end
      end
      StSearch: begin
        if (zcnt_q == ZcW'(ZOOM_LEVELS)) begin
          // past the last level
          oor_d   = 1'b1;
          zoom_d  = '0;
          coord_d = '0;
          state_d = StFinish;
        end else if (rem_fits) begin
          oor_d   = 1'b0;
          zoom_d  = ZoomW'(zcnt_q);
          kcnt_d  = '0;
          span_d  = PosW'(1);
          coord_d = '0;
          // level zero needs no walk
          state_d = (zcnt_q == '0) ? StFinish : StWalk;
        end else begin
          rem_d   = rem_q - count_q;
          count_d = count_q << 2;
          zcnt_d  = zcnt_q + ZcW'(1);
        end
      end
      StWalk: begin
        coord_d = coord_step;
        rem_d   = rem_q >> 2;
        span_d  = span_q << 1;
        kcnt_d  = kcnt_q + ZoomW'(1);
        if (kcnt_q == zoom_q - ZoomW'(1)) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output register parts the two stream sides
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (out_load) begin
      m_valid_d = 1'b1;
      m_data_d  = {PadW'(0), coord_q.y, coord_q.x, zoom_q};
      m_user_d  = oor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload and datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    count_q  <= count_d;
    zcnt_q   <= zcnt_d;
    zoom_q   <= zoom_d;
    kcnt_q   <= kcnt_d;
    span_q   <= span_d;
    oor_q    <= oor_d;
    coord_q  <= coord_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

>>> hw/rtl/hbt_d2xy_step.sv
// one level of the hilbert d2xy walk: rotate / reflect with span s, then add the quadrant
module hbt_d2xy_step (
  input  hbt_pkg::coord_t                  coord_i,
  input  logic [hbt_pkg::POS_W-1:0]        span_i,
  input  logic [1:0]                       digit_i,
  output hbt_pkg::coord_t                  coord_o
);

  localparam int unsigned PosW = hbt_pkg::POS_W;

  logic            rx;
  logic            ry;
  logic [PosW-1:0] span_m1;
  logic [PosW-1:0] xr;
  logic [PosW-1:0] yr;
  logic [PosW-1:0] xs;
  logic [PosW-1:0] ys;

  assign rx      = digit_i[1];
  assign ry      = digit_i[0] ^ digit_i[1];
  assign span_m1 = span_i - PosW'(1);

  always_comb begin
    xr = coord_i.x;
    yr = coord_i.y;
    if (rx) begin
      xr = span_m1 - coord_i.x;
      yr = span_m1 - coord_i.y;
    end
    // swap only in the lower quadrants
    if (!ry) begin
      xs = yr;
      ys = xr;
    end else begin
      xs = coord_i.x;
      ys = coord_i.y;
    end
    coord_o.x = xs + (rx ? span_i : '0);
    coord_o.y = ys + (ry ? span_i : '0);
  end

endmodule

>>> hw/rtl/hbt_checker.sv
module hbt_checker #(
  parameter int unsigned ZOOM_LEVELS = hbt_pkg::ZOOM_LEVELS_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [hbt_pkg::TILE_ID_W-1:0]    s_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [hbt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tuser
);

  logic [4:0]  zoom;
  logic [30:0] col;
  logic [30:0] row;
  logic        in_take;

  assign zoom    = m_axis_tdata[4:0];
  assign col     = m_axis_tdata[35:5];
  assign row     = m_axis_tdata[66:36];
  assign in_take = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // out-of-range result carries zero zoom and position
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (zoom == 5'd0) && (col == '0) && (row == '0))
    else $error("out-of-range result not zero");

  // column and row lie inside the level, and the level is below ZOOM_LEVELS
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      ({1'b0, col} < (32'd1 << zoom)) && ({1'b0, row} < (32'd1 << zoom))
      && (32'(zoom) < ZOOM_LEVELS))
    else $error("position outside its zoom level");

  // the unit is busy right after taking a request
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> !s_axis_tready)
    else $error("request taken while decoding");

endmodule

bind hilbert_tile_id_to_zxy_unit hbt_checker #(
  .ZOOM_LEVELS (ZOOM_LEVELS)
) u_hbt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> verif/tb_hilbert_tile_id_to_zxy_unit.sv
module tb_hilbert_tile_id_to_zxy_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEVELS       = hbt_pkg::ZOOM_LEVELS_DEF;
  // first id past the deepest level, (4^32 - 1) / 3
  localparam logic [63:0] PAST_LAST_ID = 64'h5555_5555_5555_5555;
  localparam int unsigned RANDOM_IDS   = 1250;
  // drain time after the last result, with slack beyond the slowest decode
  localparam int unsigned DRAIN_CYCLES = 80;

  // one decoded tile as the block should report it
  typedef struct packed {
    logic [hbt_pkg::ZOOM_W-1:0] zoom;
    logic [hbt_pkg::POS_W-1:0]  col;
    logic [hbt_pkg::POS_W-1:0]  row;
    logic                       past_last;
  } tile_zxy_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [hbt_pkg::TILE_ID_W-1:0]   s_axis_tdata;   // [63:0] tile_id
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [hbt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // [4:0] zoom, [35:5] x, [66:36] y, [71:67] zero
  logic                            m_axis_tuser;   // [0] out_of_range

  hilbert_tile_id_to_zxy_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // keeps the decodes of accepted requests in order and checks results against them
  class tile_scoreboard;
    tile_zxy_t expected_q[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    // level search over the id ranges, then the hilbert d2xy walk, lowest bits first
    function tile_zxy_t decode_tile_id(logic [63:0] id);
      tile_zxy_t   r;
      logic [63:0] first;
      logic [63:0] span;
      logic [63:0] pos;
      logic [63:0] cx;
      logic [63:0] cy;
      logic [63:0] t;
      logic [63:0] s;
      logic        rx;
      logic        ry;
      bit          found;
      r = '0;
      r.past_last = 1'b1;
      first = '0;
      found = 0;
      for (int z = 0; z < LEVELS; z++) begin
        if (!found) begin
          span = 64'd1 << (2 * z);
          if (id < first + span) begin
            found = 1;
            pos = id - first;
            cx = '0;
            cy = '0;
            for (int k = 0; k < z; k++) begin
              s  = 64'd1 << k;
              rx = pos[1];
              ry = pos[0] ^ rx;
              if (!ry) begin
                // rotate the quadrant, reflecting it first on the far side
                if (rx) begin
                  cx = s - 64'd1 - cx;
                  cy = s - 64'd1 - cy;
                end
                t  = cx;
                cx = cy;
                cy = t;
              end
              if (rx) cx += s;
              if (ry) cy += s;
              pos = pos >> 2;
            end
            r.zoom      = z[hbt_pkg::ZOOM_W-1:0];
            r.col       = cx[hbt_pkg::POS_W-1:0];
            r.row       = cy[hbt_pkg::POS_W-1:0];
            r.past_last = 1'b0;
          end else begin
            first += span;
          end
        end
      end
      return r;
    endfunction

    function void note_request(logic [63:0] id);
      expected_q.insert(expected_q.size(), decode_tile_id(id));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 100)
        $display("%0t ns: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    endtask

    task check_result(logic [hbt_pkg::OUT_TDATA_W-1:0] data, logic flag);
      tile_zxy_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request waiting, tdata", data[63:0], '0);
      end else begin
        want = expected_q.pop_front();
        if (data[4:0] !== want.zoom)
          report_mismatch("zoom_level", 64'(data[4:0]), 64'(want.zoom));
        if (data[35:5] !== want.col)
          report_mismatch("x_position", 64'(data[35:5]), 64'(want.col));
        if (data[66:36] !== want.row)
          report_mismatch("y_position", 64'(data[66:36]), 64'(want.row));
        if (data[71:67] !== '0)
          report_mismatch("tdata padding", 64'(data[71:67]), '0);
        if (flag !== want.past_last)
          report_mismatch("out_of_range", 64'(flag), 64'(want.past_last));
      end
    endtask
  endclass

  tile_scoreboard book;
  logic [63:0]    tile_ids[$];

  function automatic void add_tile_id(logic [63:0] id);
    tile_ids.insert(tile_ids.size(), id);
  endfunction

  // first id of zoom level z, (4^z - 1) / 3
  function automatic logic [63:0] level_first_id(int unsigned z);
    return ((64'd1 << (2 * z)) - 64'd1) / 64'd3;
  endfunction

  function automatic logic [63:0] random_u64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver: long ready stretches, choppy stretches and stalls
  int unsigned ready_hold = 0;
  always @(posedge clk_i) begin
    int unsigned pick;
    if (ready_hold == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        m_axis_tready <= 1'b1;
        ready_hold = $urandom_range(50, 300);
      end else if (pick < 7) begin
        m_axis_tready <= 1'($urandom_range(0, 1));
        ready_hold = $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        ready_hold = $urandom_range(5, 15);
      end
    end else begin
      ready_hold--;
    end
  end

  // all inputs settle between edges, so a handshake is judged at the falling edge before it
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
      book.check_result(m_axis_tdata, m_axis_tuser);
  end

  // present one tile id and hold it until the block takes the request
  task send_tile_id(logic [63:0] id);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= id;
    forever begin
      @(negedge clk_i);
      if (s_axis_tready === 1'b1) break;
      @(posedge clk_i);
    end
    book.note_request(id);
    @(posedge clk_i);
  endtask

  // hold the request stream off until every result is back
  task wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (book.pending() != 0);
  endtask

  initial begin
    int unsigned burst;
    int unsigned gap;
    int unsigned pick;
    int unsigned z;
    int unsigned n_directed;
    logic [63:0] edge_id;

    book = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;

    // directed: level zero, small levels, range edges, the deepest level and past it
    add_tile_id(64'd0);
    for (int unsigned lv = 1; lv <= 3; lv++) begin
      add_tile_id(level_first_id(lv));
      add_tile_id(level_first_id(lv + 1) - 1);
    end
    add_tile_id(64'd2);
    add_tile_id(64'd3);
    add_tile_id(level_first_id(15));
    add_tile_id(level_first_id(16) - 1);
    add_tile_id(level_first_id(30) + 64'h0AAA_AAAA_AAAA_AAAA);
    add_tile_id(level_first_id(31));
    add_tile_id(level_first_id(31) + 64'h2AAA_AAAA_AAAA_AAAA);
    add_tile_id(level_first_id(31) + 64'h1555_5555_5555_5555);
    add_tile_id(PAST_LAST_ID - 1);
    add_tile_id(PAST_LAST_ID);
    add_tile_id(PAST_LAST_ID + 1);
    add_tile_id(64'h8000_0000_0000_0000);
    add_tile_id(64'hAAAA_AAAA_AAAA_AAAA);
    add_tile_id(64'hFFFF_FFFF_FFFF_FFFF);
    n_directed = tile_ids.size();

    // random: mostly ids inside a random level, some at level edges, some raw 64-bit words
    for (int unsigned i = 0; i < RANDOM_IDS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        z = $urandom_range(0, LEVELS - 1);
        add_tile_id(level_first_id(z) + (random_u64() & ((64'd1 << (2 * z)) - 64'd1)));
      end else if (pick < 87) begin
        z = $urandom_range(1, LEVELS);
        edge_id = (z == LEVELS) ? PAST_LAST_ID : level_first_id(z);
        add_tile_id(edge_id + 64'($urandom_range(0, 3)) - 64'd2);
      end else begin
        add_tile_id(random_u64());
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part back to back, then a full drain
    for (int unsigned i = 0; i < n_directed; i++)
      send_tile_id(tile_ids[i]);
    wait_drained();

    // random part in bursts with random gaps, one more drain halfway
    for (int unsigned i = n_directed; i < tile_ids.size(); ) begin
      burst = $urandom_range(1, 24);
      for (int unsigned b = 0; b < burst && i < tile_ids.size(); b++) begin
        send_tile_id(tile_ids[i]);
        i++;
      end
      if (i >= n_directed + RANDOM_IDS / 2 && i < n_directed + RANDOM_IDS / 2 + burst) begin
        wait_drained();
      end else begin
        pick = $urandom_range(0, 9);
        gap = (pick < 4) ? 0 : (pick < 9) ? $urandom_range(1, 10) : $urandom_range(20, 40);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    // any stray result would show up within one more decode
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (book.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
